// ===== hw/rtl/dxt_pkg.sv =====
`timescale 1ns / 1ps

package dxt_pkg;

    localparam logic [1:0] FMT_DXT1  = 2'd0;
    localparam logic [1:0] FMT_DXT23 = 2'd1;
    localparam logic [1:0] FMT_DXT45 = 2'd2;

    localparam int TDATA_W = 40;

    // x/3, x/7, x/5 by reciprocal multiply; exact over the ranges used here
    localparam logic [9:0]  RECIP3 = 10'd683;   // 2^11 / 3
    localparam logic [11:0] RECIP7 = 12'd2341;  // 2^14 / 7
    localparam logic [11:0] RECIP5 = 12'd3277;  // 2^14 / 5

    typedef struct packed {
        logic [3:0][2:0][7:0] col;   // palette entry, channel 0 red
        logic                 trans3; // entry 3 is transparent black
        logic [7:0][7:0]      apal;
        logic [1:0]           fmt;
        logic [31:0]          cidx;
        logic [63:0]          ablk;
    } t_pal;

    function automatic logic [2:0][7:0] widen565(input logic [15:0] c);
        logic [2:0][7:0] w;
        w[0] = {c[15:11], c[15:13]};
        w[1] = {c[10:5], c[10:9]};
        w[2] = {c[4:0], c[4:2]};
        return w;
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] m;
        m = 20'(x) * 20'(RECIP3);
        return m[18:11];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] m;
        m = 23'(x) * 23'(RECIP7);
        return m[21:14];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] m;
        m = 23'(x) * 23'(RECIP5);
        return m[21:14];
    endfunction

endpackage

// ===== hw/rtl/dxt_pal.sv =====
`timescale 1ns / 1ps

module dxt_pal (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [63:0]  i_cblk,
    input  logic [63:0]  i_ablk,
    input  logic [1:0]   i_fmt,
    output logic         o_valid,
    input  logic         i_ready,
    output dxt_pkg::t_pal o_pal
);
    import dxt_pkg::*;

    logic rdy1, rdy2, rdy3;

    // stage 1: block capture
    logic        r_v1;
    logic [63:0] r_c1, r_a1;
    logic [1:0]  r_f1;

    // stage 2: endpoints and weighted sums
    logic                 r_v2;
    logic [1:0][2:0][7:0] r_col2;
    logic [2:0][9:0]      r_s21, r_s12;
    logic [2:0][8:0]      r_sh;
    logic                 r_four2, r_agt2;
    logic [5:0][10:0]     r_as7;
    logic [3:0][10:0]     r_as5;
    logic [1:0][7:0]      r_a01;
    logic [1:0]           r_f2;
    logic [31:0]          r_cidx2;
    logic [63:0]          r_ablk2;

    // stage 3: palettes
    logic r_v3;
    t_pal r_pal3;

    logic [1:0][2:0][7:0] n_col2;
    logic [2:0][9:0]      n_s21, n_s12;
    logic [2:0][8:0]      n_sh;
    logic [5:0][10:0]     n_as7;
    logic [3:0][10:0]     n_as5;
    logic [7:0]           a0, a1;
    t_pal                 n_pal3;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_pal   = r_pal3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_comb begin
        a0     = r_a1[7:0];
        a1     = r_a1[15:8];
        n_col2[0] = widen565(r_c1[15:0]);
        n_col2[1] = widen565(r_c1[31:16]);
        for (int c = 0; c < 3; c++) begin
            n_s21[c] = {1'b0, n_col2[0][c], 1'b0} + 10'(n_col2[1][c]);
            n_s12[c] = 10'(n_col2[0][c]) + {1'b0, n_col2[1][c], 1'b0};
            n_sh[c]  = 9'(n_col2[0][c]) + 9'(n_col2[1][c]);
        end
        for (int k = 0; k < 6; k++) begin
            n_as7[k] = 11'(a0) * 11'(6 - k) + 11'(a1) * 11'(1 + k);
        end
        for (int k = 0; k < 4; k++) begin
            n_as5[k] = 11'(a0) * 11'(4 - k) + 11'(a1) * 11'(1 + k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_c1 <= i_cblk;
            r_a1 <= i_ablk;
            r_f1 <= i_fmt;
        end
        if (rdy2 && r_v1) begin
            r_col2  <= n_col2;
            r_s21   <= n_s21;
            r_s12   <= n_s12;
            r_sh    <= n_sh;
            r_four2 <= (r_f1 != FMT_DXT1) || (r_c1[15:0] > r_c1[31:16]);
            r_agt2  <= a0 > a1;
            r_as7   <= n_as7;
            r_as5   <= n_as5;
            r_a01   <= {a1, a0};
            r_f2    <= r_f1;
            r_cidx2 <= r_c1[63:32];
            r_ablk2 <= r_a1;
        end
        if (rdy3 && r_v2) begin
            r_pal3 <= n_pal3;
        end
    end

    always_comb begin
        n_pal3        = '0;
        n_pal3.col[0] = r_col2[0];
        n_pal3.col[1] = r_col2[1];
        n_pal3.trans3 = !r_four2;
        n_pal3.fmt    = r_f2;
        n_pal3.cidx   = r_cidx2;
        n_pal3.ablk   = r_ablk2;
        for (int c = 0; c < 3; c++) begin
            if (r_four2) begin
                n_pal3.col[2][c] = div3(r_s21[c]);
                n_pal3.col[3][c] = div3(r_s12[c]);
            end else begin
                n_pal3.col[2][c] = r_sh[c][8:1];
                n_pal3.col[3][c] = 8'd0;
            end
        end
        n_pal3.apal[0] = r_a01[0];
        n_pal3.apal[1] = r_a01[1];
        if (r_agt2) begin
            for (int k = 0; k < 6; k++) begin
                n_pal3.apal[2 + k] = div7(r_as7[k]);
            end
        end else begin
            for (int k = 0; k < 4; k++) begin
                n_pal3.apal[2 + k] = div5(r_as5[k]);
            end
            n_pal3.apal[6] = 8'd0;
            n_pal3.apal[7] = 8'd255;
        end
    end

endmodule

// ===== hw/rtl/dxt_ser.sv =====
`timescale 1ns / 1ps

module dxt_ser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  dxt_pkg::t_pal                i_pal,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dxt_pkg::TDATA_W-1:0]  o_tdata,
    output logic                         o_tlast
);
    import dxt_pkg::*;

    logic               r_busy;
    logic [3:0]         r_cnt;
    t_pal               r_pal;
    logic               r_ov;
    logic [TDATA_W-1:0] r_tdata;
    logic               r_tlast;

    logic               adv, done;
    logic [1:0]         ci;
    logic [2:0]         ai;
    logic [3:0]         nib;
    logic [5:0]         abit;
    logic [7:0]         alpha;
    logic [2:0][7:0]    rgb;

    assign adv     = r_busy && (!r_ov || i_ready);
    assign done    = adv && (r_cnt == 4'd15);
    assign o_ready = !r_busy || done;
    assign o_valid = r_ov;
    assign o_tdata = r_tdata;
    assign o_tlast = r_tlast;

    always_comb begin
        abit = 6'd16 + {1'b0, r_cnt, 1'b0} + 6'(r_cnt);
        ci   = r_pal.cidx[{r_cnt, 1'b0} +: 2];
        ai   = r_pal.ablk[abit +: 3];
        nib  = r_pal.ablk[{r_cnt, 2'b00} +: 4];
        rgb  = r_pal.col[ci];
        unique case (r_pal.fmt)
            FMT_DXT1:  alpha = (ci == 2'd3 && r_pal.trans3) ? 8'd0 : 8'd255;
            FMT_DXT23: alpha = {nib, nib};
            default:   alpha = r_pal.apal[ai];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 4'd0;
            r_ov   <= 1'b0;
        end else begin
            if (o_ready && i_valid) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd0;
            end else if (adv) begin
                r_busy <= !done;
                r_cnt  <= r_cnt + 4'd1;
            end
            if (adv) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pal <= i_pal;
        end
        if (adv) begin
            r_tdata <= {4'd0, r_cnt, alpha, rgb[2], rgb[1], rgb[0]};
            r_tlast <= (r_cnt == 4'd15);
        end
    end

endmodule

// ===== hw/rtl/dxt_block_decoder_top.sv =====
`timescale 1ns / 1ps

// Compressed 4x4 texture block decoder (DXT1, DXT2/3, DXT4/5). One block beat
// in gives sixteen texel beats out in raster order, RGBA 8 bits each, tlast on
// the sixteenth. The texel serializer emits one texel per cycle while the output
// is not stalled, so under steady flow a new block is taken as the last texel of
// the previous one is emitted; the first texel beat follows three palette stages,
// serializer load, output register. The format register is written with i_cfg_we;
// the user must write it only while the block is idle; the block does not enforce it.

module dxt_block_decoder_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_wdata,   // block_format
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [127:0]                 s_axis_tdata,  // colour_block, alpha_block
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // red, green, blue, alpha, texel_position, 4'b0
    output logic [dxt_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic                         m_axis_tlast   // last_texel
);
    import dxt_pkg::*;

    logic [1:0] r_fmt;
    logic       pal_valid, ser_ready;
    t_pal       pal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_DXT1;
        end else if (i_cfg_we) begin
            r_fmt <= i_cfg_wdata;
        end
    end

    dxt_pal u_pal (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cblk  (s_axis_tdata[63:0]),
        .i_ablk  (s_axis_tdata[127:64]),
        .i_fmt   (r_fmt),
        .o_valid (pal_valid),
        .i_ready (ser_ready),
        .o_pal   (pal)
    );

    dxt_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pal_valid),
        .o_ready (ser_ready),
        .i_pal   (pal),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_tdata (m_axis_tdata),
        .o_tlast (m_axis_tlast)
    );

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[35:32] == 4'd15)))
        else $error("tlast does not match texel position");

    a_pos_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
        (m_axis_tvalid && m_axis_tdata[35:32] == $past(m_axis_tdata[35:32]) + 4'd1))
        else $error("texel beats not contiguous within a block");

endmodule
